@@ design/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same check with the reset term left out
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/ffha_pkg.sv @@
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned MAX_BLOCKS_DEF   = 32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_NRD, S_NCHK, S_MERGE,
    S_IRD, S_IWR, S_IREM, S_DRD, S_DWR, S_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_INIT, CMD_LOAD, CMD_READ, CMD_SCAN_FIT, CMD_SCAN_SKIP,
    CMD_FOUND, CMD_READ_NEXT, CMD_NEXT_CAP, CMD_NO_NEXT, CMD_MERGE,
    CMD_INS_RD, CMD_INS_WR, CMD_INS_REM, CMD_DEL_RD, CMD_DEL_WR,
    CMD_DEL_END, CMD_POST
  } dp_cmd_t;

  typedef struct packed {
    logic in_skip;   // free of address zero
    logic is_free;   // captured request is a free
    logic at_end;
    logic fit;
    logic split;
    logic match;
    logic has_next;
    logic ins_more;
    logic del_more;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/ffha_dp.sv @@
// datapath: block table memory, counters and result register
module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffha_pkg::dp_cmd_t cmd,
  output ffha_pkg::dp_stat_t stat,
  input  logic              in_action,
  input  logic [10:0]       in_size,
  input  logic [9:0]        in_addr,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [9:0]        out_result_address,
  output logic [1:0]        out_status
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int EW = 2 * AW + 1;
  localparam int SW = ((AW > 11) ? AW : 11) + 2;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);

  // entry layout: start, size, free mark in bit 0
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rdata_r, prev_r, cur_r, next_r, rem_r;
  logic          act_r;
  logic [10:0]   req_r;
  logic [9:0]    addr_r;
  logic [CW-1:0] idx_r, dst_r, count_r;
  logic [1:0]    d_r;
  logic [9:0]    res_addr_r, out_addr_r;
  logic [1:0]    res_stat_r, out_stat_r;
  logic          out_valid_r;

  logic          we, re;
  logic [IW-1:0] wa, ra;
  logic [EW-1:0] wd;

  logic [AW-1:0] rd_start, rd_size;
  logic          rd_free;
  logic [SW-1:0] hdr_w, req_w, rd_size_w, rd_start_w, addr_hdr_w;
  logic          fit, split, match, prev_free, next_free;
  logic [AW-1:0] rem_start, rem_size, m_start, m_size;
  logic [SW-1:0] m_sum;
  logic [CW-1:0] idx_inc, merge_pos;
  logic [CW:0]   del_src;

  assign rd_start   = rdata_r[EW-1:AW+1];
  assign rd_size    = rdata_r[AW:1];
  assign rd_free    = rdata_r[0];
  assign hdr_w      = SW'(HEADER_BYTES);
  assign req_w      = SW'(req_r);
  assign rd_size_w  = SW'(rd_size);
  assign rd_start_w = SW'(rd_start);
  assign addr_hdr_w = rd_start_w + hdr_w;

  assign fit   = rd_free && (rd_size_w >= req_w);
  assign split = fit && (rd_size_w > req_w + hdr_w) && (count_r < CW'(MAX_BLOCKS));
  assign match = !rd_free && (addr_hdr_w == SW'(addr_r));
  assign rem_start = AW'(addr_hdr_w + req_w);
  assign rem_size  = AW'(rd_size_w - req_w - hdr_w);

  assign idx_inc   = idx_r + CW'(1);
  assign prev_free = (idx_r != '0) && prev_r[0];
  assign next_free = next_r[0];
  assign merge_pos = prev_free ? idx_r - CW'(1) : idx_r;
  assign m_start   = prev_free ? prev_r[EW-1:AW+1] : cur_r[EW-1:AW+1];
  assign m_sum     = SW'(cur_r[AW:1])
                   + (prev_free ? SW'(prev_r[AW:1]) + hdr_w : '0)
                   + (next_free ? SW'(next_r[AW:1]) + hdr_w : '0);
  assign m_size    = AW'(m_sum);
  assign del_src   = (CW+1)'(dst_r) + (CW+1)'(d_r);

  always_comb begin
    stat.in_skip  = in_action && (in_addr == '0);
    stat.is_free  = act_r;
    stat.at_end   = (idx_r == count_r);
    stat.fit      = fit;
    stat.split    = split;
    stat.match    = match;
    stat.has_next = (idx_inc < count_r);
    stat.ins_more = (dst_r > idx_inc);
    stat.del_more = (del_src < (CW+1)'(count_r));
    stat.out_free = !out_valid_r || out_ready;
  end

  // memory port steering
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = idx_r[IW-1:0];
    ra = idx_r[IW-1:0];
    wd = rdata_r;
    unique case (cmd)
      CMD_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = {AW'(0), AW'(HEAP_BYTES - HEADER_BYTES), 1'b1};
      end
      CMD_READ:      re = 1'b1;
      CMD_READ_NEXT: begin
        re = 1'b1;
        ra = idx_inc[IW-1:0];
      end
      CMD_SCAN_FIT: begin
        we = 1'b1;
        wd = {rd_start, split ? AW'(req_r) : rd_size, 1'b0};
      end
      CMD_MERGE: begin
        we = 1'b1;
        wa = merge_pos[IW-1:0];
        wd = {m_start, m_size, 1'b1};
      end
      CMD_INS_RD: begin
        re = 1'b1;
        ra = IW'(dst_r - CW'(1));
      end
      CMD_INS_WR, CMD_DEL_WR: begin
        we = 1'b1;
        wa = dst_r[IW-1:0];
      end
      CMD_INS_REM: begin
        we = 1'b1;
        wa = idx_inc[IW-1:0];
        wd = rem_r;
      end
      CMD_DEL_RD: begin
        re = 1'b1;
        ra = del_src[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        act_r      <= in_action;
        req_r      <= in_size;
        addr_r     <= in_addr;
        res_addr_r <= '0;
        res_stat_r <= in_action ? ((in_addr != '0) ? ST_UNKNOWN : ST_OK) : ST_NOFIT;
      end
      CMD_SCAN_FIT: begin
        rem_r      <= {rem_start, rem_size, 1'b1};
        res_addr_r <= addr_hdr_w[9:0];
        res_stat_r <= ST_OK;
      end
      CMD_SCAN_SKIP: prev_r <= rdata_r;
      CMD_FOUND: begin
        cur_r      <= rdata_r;
        res_stat_r <= ST_OK;
      end
      CMD_NEXT_CAP: next_r <= rdata_r;
      CMD_NO_NEXT:  next_r <= '0;
      CMD_MERGE:    d_r <= 2'(prev_free) + 2'(next_free);
      default: ;
    endcase
    if (cmd == CMD_POST) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(1);
      idx_r       <= '0;
      dst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_LOAD:      idx_r <= '0;
        CMD_SCAN_SKIP: idx_r <= idx_inc;
        CMD_SCAN_FIT:  dst_r <= count_r;
        CMD_INS_WR:    dst_r <= dst_r - CW'(1);
        CMD_INS_REM:   count_r <= count_r + CW'(1);
        CMD_MERGE:     dst_r <= merge_pos + CW'(1);
        CMD_DEL_WR:    dst_r <= dst_r + CW'(1);
        CMD_DEL_END:   count_r <= count_r - CW'(d_r);
        default: ;
      endcase
      if (cmd == CMD_POST) out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_stat_r;

endmodule

@@ design/ffha_ctrl.sv @@
// controller: sequences scan, split, merge and table shifts
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t  cmd
);
  import ffha_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd       = CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = stat.in_skip ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        if (stat.at_end) state_nxt = S_DONE;
        else begin
          cmd       = CMD_READ;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.is_free && stat.fit) begin
          cmd       = CMD_SCAN_FIT;
          state_nxt = stat.split ? S_IRD : S_DONE;
        end else if (stat.is_free && stat.match) begin
          cmd       = CMD_FOUND;
          state_nxt = S_NRD;
        end else begin
          cmd       = CMD_SCAN_SKIP;
          state_nxt = S_RD;
        end
      end
      S_NRD: begin
        if (stat.has_next) begin
          cmd       = CMD_READ_NEXT;
          state_nxt = S_NCHK;
        end else begin
          cmd       = CMD_NO_NEXT;
          state_nxt = S_MERGE;
        end
      end
      S_NCHK: begin
        cmd       = CMD_NEXT_CAP;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd       = CMD_MERGE;
        state_nxt = S_DRD;
      end
      // open a slot after the split block, top entry first
      S_IRD: begin
        if (stat.ins_more) begin
          cmd       = CMD_INS_RD;
          state_nxt = S_IWR;
        end else state_nxt = S_IREM;
      end
      S_IWR: begin
        cmd       = CMD_INS_WR;
        state_nxt = S_IRD;
      end
      S_IREM: begin
        cmd       = CMD_INS_REM;
        state_nxt = S_DONE;
      end
      // close the gap left by merged neighbors
      S_DRD: begin
        if (stat.del_more) begin
          cmd       = CMD_DEL_RD;
          state_nxt = S_DWR;
        end else begin
          cmd       = CMD_DEL_END;
          state_nxt = S_DONE;
        end
      end
      S_DWR: begin
        cmd       = CMD_DEL_WR;
        state_nxt = S_DRD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd       = CMD_POST;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

@@ design/first_fit_heap_allocator.sv @@
// top level of the first-fit heap allocator
// One request is worked at a time. A request walks the address-ordered block
// table one entry at a time, reading and then checking each, until it finds
// its block. A split then moves every later entry up by one, reading and then
// writing each. A successful free then rewrites every later entry, shifted
// down by the number of merged neighbors, reading and then writing each, even
// when no neighbor was merged. All of this goes through the table memory, one
// read or one write at a time. After reset the block writes the initial free
// block before it takes a request. The result register lets the next request
// enter while the previous result still waits to be taken.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // request_size[10:0], block_address[20:11], zero pad
  input  logic        in_tuser,   // action: 0 allocate, 1 free
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result_address[9:0], status[11:10], zero pad
);
  import ffha_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [9:0] res_addr;
  logic [1:0] res_status;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_tuser),
    .in_size            (in_tdata[10:0]),
    .in_addr            (in_tdata[20:11]),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_result_address (res_addr),
    .out_status         (res_status)
  );

  assign out_tdata = {4'd0, res_status, res_addr};

`include "assert_macros.svh"

  // a request blocks the input until its result is posted
  `ASSERT_CLK(a_one_in_flight, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "second request accepted while busy")
  // a granted address only comes with an ok status
  `ASSERT_CLK(a_addr_ok, clk, rst_n, (out_tvalid && (out_tdata[9:0] != 10'd0)) |-> (out_tdata[11:10] == ST_OK), "address with error status")
  // status code stays in range
  `ASSERT_CLK(a_status_range, clk, rst_n, out_tvalid |-> (out_tdata[11:10] != 2'd3), "bad status code")

endmodule
